@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

@@ src/whcp_pkg.sv @@
// ----------------------------------------------------------------------------
// whcp_pkg
// Shared types and constants of the wave header chunk parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package whcp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] FMT_LEN  = 32'd16;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_RIFF   = 3'd1;
    localparam logic [2:0] ST_NO_WAVE   = 3'd2;
    localparam logic [2:0] ST_TRUNCATED = 3'd3;
    localparam logic [2:0] ST_SHORT_FMT = 3'd4;

    typedef struct packed {
        logic       valid;
        logic [7:0] stream_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic        valid;
        logic [2:0]  status;
        logic [15:0] num_channels;
        logic [12:0] sample_bytes;
        logic [31:0] rate_hz;
        logic [31:0] data_offset;
        logic [31:0] data_size;
    } t_result;

endpackage

@@ src/wave_header_chunk_parser.sv @@
// ----------------------------------------------------------------------------
// wave_header_chunk_parser
// Byte-stream RIFF/WAVE header parser, reports format and data chunk placement
// ----------------------------------------------------------------------------
// Takes one file byte per cycle and gives at most one result per file: the
// format fields and the data chunk offset and size, or an error status. A
// result is registered after the byte that completes it passes the input
// register and the core; the parser state registers update once per byte,
// so throughput is one byte per clock while the output side keeps up. A stall
// on the output holds the whole pipe only while a result waits there.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wave_header_chunk_parser
    import whcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_stream_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_num_channels,
    output logic [12:0] o_sample_bytes,
    output logic [31:0] o_rate_hz,
    output logic [31:0] o_data_offset,
    output logic [31:0] o_data_size
);

    logic    en;
    t_item   item;
    t_result core_res;
    t_result out_res;

    assign en         = !(out_res.valid && i_out_stall);
    assign o_in_stall = !en;

    whcp_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (i_in_valid),
        .i_stream_byte (i_stream_byte),
        .i_last_byte   (i_last_byte),
        .o_item        (item)
    );

    whcp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_item   (item),
        .o_result (core_res)
    );

    whcp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_result (core_res),
        .o_result (out_res)
    );

    assign o_out_valid    = out_res.valid;
    assign o_status       = out_res.status;
    assign o_num_channels = out_res.num_channels;
    assign o_sample_bytes = out_res.sample_bytes;
    assign o_rate_hz      = out_res.rate_hz;
    assign o_data_offset  = out_res.data_offset;
    assign o_data_size    = out_res.data_size;

endmodule

@@ src/whcp_in_stage.sv @@
// ----------------------------------------------------------------------------
// whcp_in_stage
// Input register, loads one transfer per enabled cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module whcp_in_stage
    import whcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  logic [7:0] i_stream_byte,
    input  logic       i_last_byte,
    output t_item      o_item
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_byte <= i_stream_byte;
            r_last <= i_last_byte;
        end
    end

    assign o_item.valid       = r_valid;
    assign o_item.stream_byte = r_byte;
    assign o_item.last_byte   = r_last;

endmodule

@@ src/whcp_core.sv @@
// ----------------------------------------------------------------------------
// whcp_core
// Parser state and per-byte next-state logic, one byte per enabled cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module whcp_core
    import whcp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_item   i_item,
    output t_result o_result
);

    localparam logic [2:0] PH_RIFF  = 3'd0;
    localparam logic [2:0] PH_CHUNK = 3'd1;
    localparam logic [2:0] PH_FMT   = 3'd2;
    localparam logic [2:0] PH_SKIP  = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    logic [2:0]  r_phase,  n_phase;
    logic [31:0] r_pos,    n_pos;
    logic [63:0] r_shift,  n_shift;
    logic [3:0]  r_fidx,   n_fidx;
    logic [31:0] r_skip,   n_skip;
    logic [15:0] r_chan,   n_chan;
    logic [15:0] r_bits,   n_bits;
    logic [31:0] r_rate,   n_rate;
    logic [31:0] r_boff,   n_boff;
    logic [31:0] r_bsize,  n_bsize;
    logic        r_fmt,    n_fmt;
    logic        r_data,   n_data;

    logic        step;
    logic [63:0] shifted;
    logic [31:0] pos_inc;
    logic [31:0] hdr_id;
    logic [31:0] hdr_size;
    logic        emit;
    logic [2:0]  emit_status;
    logic        body_start;
    logic [31:0] body_left;
    t_result     res;

    assign step     = i_en && i_item.valid;
    assign shifted  = {i_item.stream_byte, r_shift[63:8]};
    assign pos_inc  = r_pos + 32'd1;
    assign hdr_id   = shifted[31:0];
    assign hdr_size = shifted[63:32];

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_shift     = r_shift;
        n_fidx      = r_fidx;
        n_skip      = r_skip;
        n_chan      = r_chan;
        n_bits      = r_bits;
        n_rate      = r_rate;
        n_boff      = r_boff;
        n_bsize     = r_bsize;
        n_fmt       = r_fmt;
        n_data      = r_data;
        emit        = 1'b0;
        emit_status = ST_OK;
        body_start  = 1'b0;
        body_left   = '0;
        res         = '0;

        if (step) begin
            if (r_phase < PH_DONE) begin
                n_pos   = pos_inc;
                n_shift = shifted;
            end

            unique case (r_phase)
                PH_RIFF: begin
                    if (r_fidx == 4'd3 && hdr_size != TAG_RIFF) begin
                        emit        = 1'b1;
                        emit_status = ST_NO_RIFF;
                    end else if (r_fidx == 4'd11) begin
                        n_fidx = '0;
                        if (hdr_size != TAG_WAVE) begin
                            emit        = 1'b1;
                            emit_status = ST_NO_WAVE;
                        end else begin
                            n_phase = PH_CHUNK;
                        end
                    end else begin
                        n_fidx = r_fidx + 4'd1;
                    end
                end
                PH_CHUNK: begin
                    if (r_fidx == 4'd7) begin
                        n_fidx = '0;
                        if (hdr_id == TAG_FMT) begin
                            if (hdr_size < FMT_LEN) begin
                                emit        = 1'b1;
                                emit_status = ST_SHORT_FMT;
                            end else begin
                                n_skip  = hdr_size - FMT_LEN;
                                n_phase = PH_FMT;
                            end
                        end else if (hdr_id == TAG_DATA) begin
                            n_boff  = pos_inc;
                            n_bsize = hdr_size;
                            n_data  = 1'b1;
                            if (r_fmt) begin
                                emit = 1'b1;
                            end else begin
                                body_start = 1'b1;
                                body_left  = hdr_size;
                            end
                        end else begin
                            body_start = 1'b1;
                            body_left  = hdr_size;
                        end
                    end else begin
                        n_fidx = r_fidx + 4'd1;
                    end
                end
                PH_FMT: begin
                    if (r_fidx == 4'd7) begin
                        n_chan = shifted[31:16];
                        n_rate = shifted[63:32];
                        n_fidx = r_fidx + 4'd1;
                    end else if (r_fidx == 4'd15) begin
                        n_bits = shifted[63:48];
                        n_fmt  = 1'b1;
                        n_fidx = '0;
                        if (r_data) begin
                            emit = 1'b1;
                        end else begin
                            body_start = 1'b1;
                            body_left  = r_skip;
                        end
                    end else begin
                        n_fidx = r_fidx + 4'd1;
                    end
                end
                PH_SKIP: begin
                    if (r_skip <= 32'd1) begin
                        n_skip  = '0;
                        n_phase = PH_CHUNK;
                        n_fidx  = '0;
                    end else begin
                        n_skip = r_skip - 32'd1;
                    end
                end
                default: begin
                end
            endcase

            if (body_start) begin
                if (body_left == '0) begin
                    n_phase = PH_CHUNK;
                    n_fidx  = '0;
                end else begin
                    n_skip  = body_left;
                    n_phase = PH_SKIP;
                end
            end

            if (emit) begin
                n_phase    = PH_DONE;
                res.valid  = 1'b1;
                res.status = emit_status;
                if (emit_status == ST_OK) begin
                    res.num_channels = n_chan;
                    res.sample_bytes = n_bits[15:3];
                    res.rate_hz      = n_rate;
                    res.data_offset  = n_boff;
                    res.data_size    = n_bsize;
                end
            end

            if (i_item.last_byte) begin
                if (!emit && n_phase < PH_DONE) begin
                    res.valid  = 1'b1;
                    res.status = ST_TRUNCATED;
                end
                n_phase = PH_RIFF;
                n_pos   = '0;
                n_shift = '0;
                n_fidx  = '0;
                n_skip  = '0;
                n_chan  = '0;
                n_bits  = '0;
                n_rate  = '0;
                n_boff  = '0;
                n_bsize = '0;
                n_fmt   = 1'b0;
                n_data  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RIFF;
            r_pos   <= '0;
            r_shift <= '0;
            r_fidx  <= '0;
            r_skip  <= '0;
            r_chan  <= '0;
            r_bits  <= '0;
            r_rate  <= '0;
            r_boff  <= '0;
            r_bsize <= '0;
            r_fmt   <= 1'b0;
            r_data  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_shift <= n_shift;
            r_fidx  <= n_fidx;
            r_skip  <= n_skip;
            r_chan  <= n_chan;
            r_bits  <= n_bits;
            r_rate  <= n_rate;
            r_boff  <= n_boff;
            r_bsize <= n_bsize;
            r_fmt   <= n_fmt;
            r_data  <= n_data;
        end
    end

    assign o_result = res;

    `ASSERT_ALWAYS(a_done_after_result, i_clk, i_rst_n, step && res.valid && !i_item.last_byte |=> r_phase == PH_DONE)
    `ASSERT_ALWAYS(a_rearm_on_last, i_clk, i_rst_n, step && i_item.last_byte |=> r_phase == PH_RIFF && r_fidx == 4'd0 && !r_fmt && !r_data)
    `ASSERT_NEVER(a_error_fields_zero, i_clk, i_rst_n, res.valid && res.status != ST_OK && (res.rate_hz != '0 || res.data_size != '0 || res.num_channels != '0))
    `ASSERT_NEVER(a_no_result_when_done, i_clk, i_rst_n, step && r_phase == PH_DONE && res.valid)

endmodule

@@ src/whcp_out_stage.sv @@
// ----------------------------------------------------------------------------
// whcp_out_stage
// Result register, holds a result until its transfer completes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module whcp_out_stage
    import whcp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_result i_result,
    output t_result o_result
);

    logic    r_valid;
    t_result r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_result.valid) begin
            r_data <= i_result;
        end
    end

    always_comb begin
        o_result       = r_data;
        o_result.valid = r_valid;
    end

endmodule
